@@ hdl/sound_command_stack_sequencer_assert.svh @@
// Assertion macros for the sound command stack sequencer.
`ifndef SOUND_COMMAND_STACK_SEQUENCER_ASSERT_SVH
`define SOUND_COMMAND_STACK_SEQUENCER_ASSERT_SVH

// Consequent checked in the cycle after the antecedent, outside reset.
`define SCSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Consequent checked in the same cycle as the antecedent, outside reset.
`define SCSS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after reset is sampled.
`define SCSS_ASSERT_RESET(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/scss_pkg.sv @@
// Shared types, codes and byte functions of the sound command stack sequencer.
package scss_pkg;

  localparam logic [7:0] CMD_NULL_A     = 8'h00;
  localparam logic [7:0] CMD_NULL_B     = 8'h80;
  localparam logic [7:0] CMD_MUSIC_LO   = 8'h81;
  localparam logic [7:0] CMD_MUSIC_HI   = 8'h8f;
  localparam logic [7:0] CMD_MUSIC_TOP  = 8'hf0;
  localparam logic [7:0] CMD_BEGIN_COLL = 8'he4;
  localparam logic [7:0] CMD_END_COLL   = 8'he6;
  localparam logic [7:0] CMD_PLAIN_E    = 8'hea;
  localparam logic [7:0] CMD_DELAY_LO   = 8'he0;
  localparam logic [7:0] SAMPLE_MASK    = 8'h3f;
  localparam logic [7:0] SAMPLE_FLAG    = 8'h80;

  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_BEGIN,
    CLS_END,
    CLS_SINGLE,
    CLS_PLAIN
  } cmd_class_t;

  typedef enum logic [1:0] {
    WR_STOP,
    WR_SAMPLE,
    WR_START
  } wr_phase_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } seq_state_t;

  // Hand-off of one byte to send from the controller to the write sequencer.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } send_req_t;

  function automatic cmd_class_t classify(input logic [7:0] b);
    cmd_class_t cls;
    if (b == CMD_NULL_A || b == CMD_NULL_B) begin
      cls = CLS_NONE;
    end else if ((b >= CMD_MUSIC_LO && b <= CMD_MUSIC_HI) || b >= CMD_MUSIC_TOP) begin
      cls = CLS_NONE;
    end else if (b == CMD_BEGIN_COLL) begin
      cls = CLS_BEGIN;
    end else if (b == CMD_END_COLL) begin
      cls = CLS_END;
    end else if (b >= CMD_DELAY_LO && b != CMD_PLAIN_E) begin
      cls = CLS_SINGLE;
    end else begin
      cls = CLS_PLAIN;
    end
    return cls;
  endfunction

  // Bank select: highest set bit among bits 7, 6 and 5.
  function automatic logic [7:0] stop_code(input logic [7:0] b);
    logic [7:0] code;
    if (b[7]) begin
      code = 8'h40;
    end else if (b[6]) begin
      code = 8'h20;
    end else if (b[5]) begin
      code = 8'h10;
    end else begin
      code = 8'h08;
    end
    return code;
  endfunction

  function automatic logic [7:0] start_code(input logic [7:0] b);
    logic [7:0] code;
    if (b[7]) begin
      code = 8'h80;
    end else if (b[6]) begin
      code = 8'h40;
    end else if (b[5]) begin
      code = 8'h20;
    end else begin
      code = 8'h10;
    end
    return code;
  endfunction

  function automatic logic [7:0] chip_byte(input logic [7:0] b, input wr_phase_t ph);
    logic [7:0] v;
    case (ph)
      WR_STOP:   v = stop_code(b);
      WR_SAMPLE: v = SAMPLE_FLAG | (b & SAMPLE_MASK);
      WR_START:  v = start_code(b);
      default:   v = stop_code(b);
    endcase
    return v;
  endfunction

endpackage

@@ hdl/scss_if.sv @@
// Valid/ready channel interfaces for command items and chip write items.
interface scss_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] command_byte;
  logic [3:0] chip_voices_busy;

  modport source (output valid, output kind, output command_byte,
                  output chip_voices_busy, input ready);
  modport sink   (input valid, input kind, input command_byte,
                  input chip_voices_busy, output ready);
endinterface

interface scss_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] chip_write_byte;
  logic       last_write;

  modport source (output valid, output chip_write_byte, output last_write, input ready);
  modport sink   (input valid, input chip_write_byte, input last_write, output ready);
endinterface

@@ hdl/sound_command_stack_sequencer.sv @@
// Top level of the sound command stack sequencer.
//
// Channels: in_item carries one item per handshake, either a command byte
// (kind 0) or a playback timer tick (kind 1) with the chip voice status.
// out_item carries chip data port writes; every byte sent gives three items
// in a row (voice stop, sample code, voice start), the last flagged by
// last_write. Both channels complete an item when valid and ready are high.
// Timing: an immediate byte shows its first write the cycle after it is
// accepted; a popped byte once the stack RAM read is registered and the
// read data has gone to the write sequencer. An item that sends holds the
// input until its three writes are taken, and a pop waits for the RAM read
// first; other items leave the input free for the next item.
// in_item.ready stays low while a byte is still being written out, so a
// stall on out_item holds the write and backs up the input.
// Reset (rst_n low, synchronous) empties the stack, stops collecting,
// disarms playback and drops any write in flight. The stack RAM keeps its
// contents; only entries below the level are ever read.
module sound_command_stack_sequencer #(
  parameter int STACK_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  scss_in_if.sink    in_item,
  scss_out_if.source out_item
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int LW = $clog2(STACK_DEPTH + 1);

  scss_pkg::seq_state_t state_r, state_nxt;
  logic [LW-1:0]        level_r, level_nxt;
  logic                 coll_r, coll_nxt;
  logic                 armed_r, armed_nxt;

  logic                 in_acc;
  logic                 pop_start;
  logic                 wr_busy;
  scss_pkg::cmd_class_t cls;
  scss_pkg::send_req_t  req;

  logic                 ram_wr_en;
  logic [AW-1:0]        ram_wr_addr;
  logic                 ram_rd_en;
  logic [AW-1:0]        ram_rd_addr;
  logic [7:0]           ram_rd_data;

  assign in_acc = in_item.valid & in_item.ready;
  assign cls    = scss_pkg::classify(in_item.command_byte);

  // Command and tick decode: update stack level and flags, push or pop.
  always_comb begin
    level_nxt   = level_r;
    coll_nxt    = coll_r;
    armed_nxt   = armed_r;
    ram_wr_en   = 1'b0;
    ram_wr_addr = level_r[AW-1:0];
    ram_rd_en   = 1'b0;
    ram_rd_addr = AW'(level_r - LW'(1));
    pop_start   = 1'b0;
    req.valid   = 1'b0;
    req.data    = in_item.command_byte;

    if (in_acc) begin
      if (in_item.kind) begin
        if (armed_r) begin
          if (level_r == '0) begin
            armed_nxt = 1'b0;
          end else if (in_item.chip_voices_busy == '0) begin
            // pop the top entry; data returns next cycle
            level_nxt = level_r - LW'(1);
            ram_rd_en = 1'b1;
            pop_start = 1'b1;
          end
        end
      end else begin
        case (cls)
          scss_pkg::CLS_BEGIN: begin
            coll_nxt  = 1'b1;
            level_nxt = '0;
          end
          scss_pkg::CLS_END: begin
            coll_nxt  = 1'b0;
            armed_nxt = 1'b1;
          end
          scss_pkg::CLS_SINGLE: begin
            // stack holds only this byte
            coll_nxt    = 1'b0;
            armed_nxt   = 1'b1;
            ram_wr_en   = 1'b1;
            ram_wr_addr = '0;
            level_nxt   = LW'(1);
          end
          scss_pkg::CLS_PLAIN: begin
            if (coll_r) begin
              // push unless full; a full stack drops the byte
              if (level_r < LW'(STACK_DEPTH)) begin
                ram_wr_en = 1'b1;
                level_nxt = level_r + LW'(1);
              end
            end else begin
              req.valid = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end

    // hand the popped byte to the write sequencer
    if (state_r == scss_pkg::ST_READ) begin
      req.valid = 1'b1;
      req.data  = ram_rd_data;
    end
  end

  // Next state: a pop waits in ST_READ for the RAM read.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      scss_pkg::ST_IDLE: if (pop_start) state_nxt = scss_pkg::ST_READ;
      scss_pkg::ST_READ: state_nxt = scss_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the state machine: take an item only when nothing is in flight.
  always_comb begin
    in_item.ready = 1'b0;
    unique case (state_r)
      scss_pkg::ST_IDLE: in_item.ready = ~wr_busy;
      scss_pkg::ST_READ: in_item.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scss_pkg::ST_IDLE;
      level_r <= '0;
      coll_r  <= 1'b0;
      armed_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      level_r <= level_nxt;
      coll_r  <= coll_nxt;
      armed_r <= armed_nxt;
    end
  end

  scss_ram #(
    .WIDTH (8),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (in_item.command_byte),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  scss_writer u_writer (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .busy     (wr_busy),
    .out_item (out_item)
  );

endmodule

@@ hdl/scss_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read.
module scss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/scss_writer.sv @@
// Write sequencer: turns one byte into stop, sample and start chip writes.
module scss_writer (
  input  logic                clk,
  input  logic                rst_n,
  input  scss_pkg::send_req_t req,
  output logic                busy,
  scss_out_if.source          out_item
);

  logic                busy_r, busy_nxt;
  scss_pkg::wr_phase_t phase_r, phase_nxt;
  logic [7:0]          data_r, data_nxt;
  logic                out_acc;

  assign out_acc = out_item.valid & out_item.ready;

  always_comb begin
    busy_nxt  = busy_r;
    phase_nxt = phase_r;
    data_nxt  = data_r;
    if (req.valid) begin
      busy_nxt  = 1'b1;
      phase_nxt = scss_pkg::WR_STOP;
      data_nxt  = req.data;
    end else if (out_acc) begin
      case (phase_r)
        scss_pkg::WR_STOP:   phase_nxt = scss_pkg::WR_SAMPLE;
        scss_pkg::WR_SAMPLE: phase_nxt = scss_pkg::WR_START;
        default: begin
          // drop busy after the start write
          busy_nxt  = 1'b0;
          phase_nxt = scss_pkg::WR_STOP;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= scss_pkg::WR_STOP;
    end else begin
      busy_r  <= busy_nxt;
      phase_r <= phase_nxt;
    end
    data_r <= data_nxt;
  end

  assign busy                     = busy_r;
  assign out_item.valid           = busy_r;
  assign out_item.chip_write_byte = scss_pkg::chip_byte(data_r, phase_r);
  assign out_item.last_write      = (phase_r == scss_pkg::WR_START);

endmodule

@@ hdl/scss_checker.sv @@
// Port-level checker of the sound command stack sequencer, with its bind.
`include "sound_command_stack_sequencer_assert.svh"

module scss_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);

  `SCSS_ASSERT_RESET(a_reset_clears_out, !out_valid, "write pending after reset")
  `SCSS_ASSERT_SAME(a_no_take_while_writing, in_ready, !out_valid, "item taken during writes")
  `SCSS_ASSERT_NEXT(a_writes_contiguous, out_valid && out_ready && !out_last, out_valid, "gap in write group")
  `SCSS_ASSERT_NEXT(a_last_not_repeated, out_valid && out_ready && out_last, !out_valid || !out_last, "two last writes in a row")
  `SCSS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_last), "stalled write changed")

endmodule

bind sound_command_stack_sequencer scss_checker u_scss_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_item.ready),
  .out_valid (out_item.valid),
  .out_ready (out_item.ready),
  .out_byte  (out_item.chip_write_byte),
  .out_last  (out_item.last_write)
);
